### src/hbwd_pkg.sv
// Shared types and constants for the dual heartbeat watchdog.
package hbwd_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHED_STATE = 2'd1;

  // Field widths fixed by the interface.
  localparam int SEQ_W   = 32;
  localparam int MODE_W  = 8;
  localparam int LIMIT_W = 16;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 16'd60000;
  localparam logic [MODE_W-1:0]  WATCHED_STATE_RST = 8'd3;

  // Latched trip cause.
  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_KERNEL = 2'd1,
    CAUSE_WORKER = 2'd2
  } cause_t;

endpackage

### src/dual_heartbeat_watchdog.sv
// Dual heartbeat watchdog: checks a kernel pet sequence and a worker heartbeat per poll tick.
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  ------------------------------------------
//   in        sink       in_valid / in_ready     kernel_seq, worker_seq, worker_mode
//   out       source     out_valid / out_ready   tripped, trip_cause, seen_kernel_seq,
//                                                seen_worker_seq, pet_total
//   cfg       sink       cfg_we (no wait)        cfg_index, cfg_data
//
// One poll tick is one beat. The whole update for a tick is a compare, a saturating
// increment and a limit compare per channel, done in the cycle the beat is accepted,
// so a new beat can be taken every cycle unless the output stalls: the rate is one tick per clock.
// The state registers double as the result register; out_valid marks a result that
// has not yet been taken, and a new input beat is taken whenever that slot is empty
// or is being emptied in the same cycle, so only a stalled output holds the input off.
// Reset (rst, synchronous, active high) clears all state and restores the register reset
// values; there is no clearing pass.
module dual_heartbeat_watchdog #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hbwd_pkg::SEQ_W-1:0]        kernel_seq,
  input  logic [hbwd_pkg::SEQ_W-1:0]        worker_seq,
  input  logic [hbwd_pkg::MODE_W-1:0]       worker_mode,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              tripped,
  output logic [1:0]                        trip_cause,
  output logic [hbwd_pkg::SEQ_W-1:0]        seen_kernel_seq,
  output logic [hbwd_pkg::SEQ_W-1:0]        seen_worker_seq,
  output logic [hbwd_pkg::SEQ_W-1:0]        pet_total,

  input  logic                              cfg_we,
  input  logic [hbwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The limit compare runs at whichever is wider, the count or the limit, so that a
  // limit at or above the count ceiling can never be exceeded.
  localparam int CMP_W = (COUNT_WIDTH > hbwd_pkg::LIMIT_W) ? COUNT_WIDTH : hbwd_pkg::LIMIT_W;

  // Configuration registers.
  logic [hbwd_pkg::LIMIT_W-1:0] timeout_limit;
  logic [hbwd_pkg::MODE_W-1:0]  watched_state;

  // Watchdog state.
  logic                         primed;
  logic                         halted;
  hbwd_pkg::cause_t             cause;
  logic [hbwd_pkg::SEQ_W-1:0]   last_kernel;
  logic [hbwd_pkg::SEQ_W-1:0]   prev_worker;
  logic [COUNT_WIDTH-1:0]       kernel_count;
  logic [COUNT_WIDTH-1:0]       worker_count;
  logic [hbwd_pkg::SEQ_W-1:0]   pets;

  logic                         primed_next;
  logic                         halted_next;
  hbwd_pkg::cause_t             cause_next;
  logic [hbwd_pkg::SEQ_W-1:0]   last_kernel_next;
  logic [hbwd_pkg::SEQ_W-1:0]   prev_worker_next;
  logic [COUNT_WIDTH-1:0]       kernel_count_next;
  logic [COUNT_WIDTH-1:0]       worker_count_next;
  logic [hbwd_pkg::SEQ_W-1:0]   pets_next;

  logic                         in_beat;
  logic                         out_beat;

  // Per-channel tick evaluation.
  logic                         kernel_same;
  logic [COUNT_WIDTH-1:0]       kernel_inc;
  logic                         kernel_trip;
  logic                         worker_same;
  logic                         worker_watch;
  logic [COUNT_WIDTH-1:0]       worker_inc;
  logic                         worker_trip;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;
  assign in_ready = !out_valid || out_ready;

  // Idle counts saturate at all ones instead of wrapping.
  assign kernel_inc = (&kernel_count) ? kernel_count : kernel_count + COUNT_WIDTH'(1);
  assign worker_inc = (&worker_count) ? worker_count : worker_count + COUNT_WIDTH'(1);

  assign kernel_same  = (kernel_seq == last_kernel);
  assign kernel_trip  = kernel_same && (CMP_W'(kernel_inc) > CMP_W'(timeout_limit));
  assign worker_same  = (worker_seq == prev_worker);
  assign worker_watch = (worker_mode == watched_state);
  assign worker_trip  = worker_same && worker_watch &&
                        (CMP_W'(worker_inc) > CMP_W'(timeout_limit));

  // Next state for one accepted tick. The kernel channel is checked first; when it
  // trips, the worker channel is left untouched on that tick.
  always_comb begin
    primed_next       = primed;
    halted_next       = halted;
    cause_next        = cause;
    last_kernel_next  = last_kernel;
    prev_worker_next  = prev_worker;
    kernel_count_next = kernel_count;
    worker_count_next = worker_count;
    pets_next         = pets;

    if (halted) begin
      // Frozen after a trip: only the pet total keeps moving.
      pets_next = pets + 32'd1;
    end else if (!primed) begin
      // First tick after reset just records both sequences.
      primed_next       = 1'b1;
      last_kernel_next  = kernel_seq;
      prev_worker_next  = worker_seq;
      kernel_count_next = '0;
      worker_count_next = '0;
      pets_next         = '0;
    end else begin
      if (!kernel_same) begin
        last_kernel_next  = kernel_seq;
        kernel_count_next = '0;
        pets_next         = pets + 32'd1;
      end else begin
        kernel_count_next = kernel_inc;
      end

      if (kernel_trip) begin
        halted_next = 1'b1;
        cause_next  = hbwd_pkg::CAUSE_KERNEL;
      end else if (!worker_same) begin
        // A new heartbeat clears the worker count whatever the mode.
        prev_worker_next  = worker_seq;
        worker_count_next = '0;
      end else if (worker_watch) begin
        worker_count_next = worker_inc;
        if (worker_trip) begin
          halted_next = 1'b1;
          cause_next  = hbwd_pkg::CAUSE_WORKER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= hbwd_pkg::TIMEOUT_LIMIT_RST;
      watched_state <= hbwd_pkg::WATCHED_STATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbwd_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        hbwd_pkg::REG_WATCHED_STATE: watched_state <= cfg_data[hbwd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed       <= 1'b0;
      halted       <= 1'b0;
      cause        <= hbwd_pkg::CAUSE_NONE;
      last_kernel  <= '0;
      prev_worker  <= '0;
      kernel_count <= '0;
      worker_count <= '0;
      pets         <= '0;
    end else if (in_beat) begin
      primed       <= primed_next;
      halted       <= halted_next;
      cause        <= cause_next;
      last_kernel  <= last_kernel_next;
      prev_worker  <= prev_worker_next;
      kernel_count <= kernel_count_next;
      worker_count <= worker_count_next;
      pets         <= pets_next;
    end
  end

  // A result is pending from the tick that produced it until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  // The state after the last tick is the result itself.
  assign tripped         = halted;
  assign trip_cause      = cause;
  assign seen_kernel_seq = last_kernel;
  assign seen_worker_seq = prev_worker;
  assign pet_total       = pets;

  // Once tripped, the flag stays set until reset.
  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    tripped |=> tripped)
    else $error("timeout flag cleared without reset");

  // A cause is latched exactly when the block has tripped.
  a_cause_matches: assert property (@(posedge clk) disable iff (rst)
    tripped == (trip_cause != hbwd_pkg::CAUSE_NONE))
    else $error("trip cause disagrees with timeout flag");

  // While frozen, each accepted tick moves the pet total by exactly one.
  a_frozen_pets: assert property (@(posedge clk) disable iff (rst)
    (in_beat && tripped) |=> (pet_total == $past(pet_total) + 32'd1))
    else $error("pet total did not advance by one while frozen");

  // Recorded sequences change only on an accepted tick.
  a_seq_hold: assert property (@(posedge clk) disable iff (rst)
    !in_beat |=> ($stable(seen_kernel_seq) && $stable(seen_worker_seq)))
    else $error("recorded sequence changed without an input beat");

endmodule

### verif/testbench.sv
// Self-checking testbench for the dual heartbeat watchdog.
`timescale 1ns / 100ps

module testbench;

  // Idle-count width the block is built with.
  localparam int COUNT_W = 16;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS = 44;
  localparam int SOAK_TICKS = 20;
  localparam int FROZEN_TICKS = 20;

  // Indexes that the block has no register behind; writes there must be ignored.
  localparam logic [hbwd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [hbwd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  // One poll tick as offered on the input channel.
  typedef struct {
    logic [hbwd_pkg::SEQ_W-1:0]  kseq;
    logic [hbwd_pkg::SEQ_W-1:0]  wseq;
    logic [hbwd_pkg::MODE_W-1:0] mode;
  } tick_t;

  // Everything the watchdog remembers between ticks. The visible result of a tick
  // is read straight out of this record after the tick has been applied.
  typedef struct {
    logic                       primed;
    logic [hbwd_pkg::SEQ_W-1:0] last_k;
    logic [hbwd_pkg::SEQ_W-1:0] last_w;
    logic [COUNT_W-1:0]         k_cnt;
    logic [COUNT_W-1:0]         w_cnt;
    logic                       halted;
    hbwd_pkg::cause_t           cause;
    logic [hbwd_pkg::SEQ_W-1:0] pets;
  } wd_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [hbwd_pkg::SEQ_W-1:0]  kernel_seq = '0;
  logic [hbwd_pkg::SEQ_W-1:0]  worker_seq = '0;
  logic [hbwd_pkg::MODE_W-1:0] worker_mode = '0;

  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        tripped;
  logic [1:0]                  trip_cause;
  logic [hbwd_pkg::SEQ_W-1:0]  seen_kernel_seq;
  logic [hbwd_pkg::SEQ_W-1:0]  seen_worker_seq;
  logic [hbwd_pkg::SEQ_W-1:0]  pet_total;

  logic                            cfg_we = 1'b0;
  logic [hbwd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hbwd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dual_heartbeat_watchdog #(.COUNT_WIDTH(COUNT_W)) dut (.*);

  always #10 clk = ~clk;

  // Ticks waiting to be driven, and the status owed for every accepted tick.
  tick_t     ticks_pending[$];
  wd_state_t status_due[$];

  // Checker-side copy of the block state and registers, advanced on accepted beats
  // and observed register writes.
  wd_state_t                    wd_now;
  logic [hbwd_pkg::LIMIT_W-1:0] lim_now = hbwd_pkg::TIMEOUT_LIMIT_RST;
  logic [hbwd_pkg::MODE_W-1:0]  wat_now = hbwd_pkg::WATCHED_STATE_RST;

  // A second copy that the stimulus side runs ahead with, so that it knows which
  // tick would trip the watchdog and can steer around it until the run wants a trip.
  wd_state_t                    wd_plan;
  logic [hbwd_pkg::LIMIT_W-1:0] plan_limit = hbwd_pkg::TIMEOUT_LIMIT_RST;
  logic [hbwd_pkg::MODE_W-1:0]  plan_watched = hbwd_pkg::WATCHED_STATE_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int run_cycles = 0;
  bit in_fire = 1'b0;

  // Applies one poll tick to a watchdog state. The kernel channel goes first; a
  // kernel trip on this tick leaves the worker channel untouched. Idle counts stop
  // at their all-ones value rather than wrapping.
  function automatic wd_state_t watchdog_tick(wd_state_t s, tick_t t,
                                              logic [hbwd_pkg::LIMIT_W-1:0] limit,
                                              logic [hbwd_pkg::MODE_W-1:0] watched);
    if (s.halted) begin
      s.pets++;
    end else if (!s.primed) begin
      s.primed = 1'b1;
      s.last_k = t.kseq;
      s.last_w = t.wseq;
      s.k_cnt  = '0;
      s.w_cnt  = '0;
      s.pets   = '0;
    end else begin
      if (t.kseq != s.last_k) begin
        s.last_k = t.kseq;
        s.k_cnt  = '0;
        s.pets++;
      end else begin
        if (s.k_cnt != '1) s.k_cnt++;
        if (s.k_cnt > limit) begin
          s.halted = 1'b1;
          s.cause  = hbwd_pkg::CAUSE_KERNEL;
        end
      end
      if (!s.halted) begin
        // A new worker heartbeat clears the count in any mode.
        if (t.wseq != s.last_w) begin
          s.last_w = t.wseq;
          s.w_cnt  = '0;
        end else if (t.mode == watched) begin
          if (s.w_cnt != '1) s.w_cnt++;
          if (s.w_cnt > limit) begin
            s.halted = 1'b1;
            s.cause  = hbwd_pkg::CAUSE_WORKER;
          end
        end
      end
    end
    return s;
  endfunction

  function automatic logic [hbwd_pkg::SEQ_W-1:0] fresh_seq(logic [hbwd_pkg::SEQ_W-1:0] old);
    logic [hbwd_pkg::SEQ_W-1:0] v;
    v = $urandom;
    if (v == old) v = ~old;
    return v;
  endfunction

  task automatic flag(string what, logic [hbwd_pkg::SEQ_W-1:0] want,
                      logic [hbwd_pkg::SEQ_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Queues a tick for the driver. Unless a trip is wanted, a tick that would trip
  // gets a fresh sequence on the offending channel; two passes cover both channels.
  task automatic queue_tick(tick_t t, bit may_trip);
    wd_state_t nxt;
    nxt = watchdog_tick(wd_plan, t, plan_limit, plan_watched);
    if (!may_trip) begin
      repeat (2) begin
        if (nxt.halted) begin
          if (nxt.cause == hbwd_pkg::CAUSE_KERNEL) t.kseq = fresh_seq(wd_plan.last_k);
          else t.wseq = fresh_seq(wd_plan.last_w);
          nxt = watchdog_tick(wd_plan, t, plan_limit, plan_watched);
        end
      end
    end
    wd_plan = nxt;
    ticks_pending.push_back(t);
  endtask

  task automatic directed_tick(logic [hbwd_pkg::SEQ_W-1:0] k, logic [hbwd_pkg::SEQ_W-1:0] w,
                               logic [hbwd_pkg::MODE_W-1:0] m);
    tick_t t;
    t.kseq = k;
    t.wseq = w;
    t.mode = m;
    queue_tick(t, 1'b0);
  endtask

  // Random ticks: each channel keeps or replaces its sequence with the given odds,
  // and the worker sits in the watched state with the given odds.
  task automatic make_ticks(int n, int kchg_pct, int wchg_pct, int watch_pct,
                            bit may_trip);
    tick_t t;
    repeat (n) begin
      t.kseq = ($urandom_range(99) < kchg_pct) ? fresh_seq(wd_plan.last_k) : wd_plan.last_k;
      t.wseq = ($urandom_range(99) < wchg_pct) ? fresh_seq(wd_plan.last_w) : wd_plan.last_w;
      t.mode = ($urandom_range(99) < watch_pct) ? plan_watched
                                                : hbwd_pkg::MODE_W'($urandom_range(255));
      queue_tick(t, may_trip);
    end
  endtask

  task automatic write_reg(logic [hbwd_pkg::CFG_IDX_W-1:0] idx,
                           logic [hbwd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      hbwd_pkg::REG_TIMEOUT_LIMIT: plan_limit = data;
      hbwd_pkg::REG_WATCHED_STATE: plan_watched = data[hbwd_pkg::MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(idling_t how);
    case (how)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 48; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      IDLE_BOTH:     begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Waits until every queued tick has been accepted and its status has come back.
  // Sampling on the rising edge keeps this clear of the driver's falling-edge updates.
  task automatic drain();
    do @(posedge clk);
    while (ticks_pending.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  // Driver: a new beat is offered only when the line is empty or the last beat was
  // taken at the previous rising edge; otherwise valid and payload hold.
  always @(negedge clk) begin : feed
    tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = ticks_pending.pop_front();
        in_valid    <= 1'b1;
        kernel_seq  <= t.kseq;
        worker_seq  <= t.wseq;
        worker_mode <= t.mode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready. A hold request from the stimulus turns into a long stretch of
  // back-pressure that this process counts down by itself; otherwise ready stalls at
  // random with the current odds.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result beat against the oldest owed status, then advances
  // the checker's state for a beat accepted on this edge. A register write is applied
  // last, since it only affects ticks after it.
  always @(posedge clk) begin : watch_beats
    wd_state_t want;
    tick_t     t;
    in_fire = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          flag("unexpected result beat, pet_total", '0, pet_total);
        end else begin
          want = status_due.pop_front();
          if (tripped !== want.halted)
            flag("tripped", hbwd_pkg::SEQ_W'(want.halted), hbwd_pkg::SEQ_W'(tripped));
          if (trip_cause !== want.cause)
            flag("trip_cause", hbwd_pkg::SEQ_W'(want.cause), hbwd_pkg::SEQ_W'(trip_cause));
          if (seen_kernel_seq !== want.last_k)
            flag("seen_kernel_seq", want.last_k, seen_kernel_seq);
          if (seen_worker_seq !== want.last_w)
            flag("seen_worker_seq", want.last_w, seen_worker_seq);
          if (pet_total !== want.pets) flag("pet_total", want.pets, pet_total);
        end
      end
      if (in_fire) begin
        t.kseq = kernel_seq;
        t.wseq = worker_seq;
        t.mode = worker_mode;
        wd_now = watchdog_tick(wd_now, t, lim_now, wat_now);
        status_due.push_back(wd_now);
      end
      if (cfg_we) begin
        case (cfg_index)
          hbwd_pkg::REG_TIMEOUT_LIMIT: lim_now = cfg_data;
          hbwd_pkg::REG_WATCHED_STATE: wat_now = cfg_data[hbwd_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hard stop in case the block hangs either channel.
  always @(posedge clk) begin
    run_cycles++;
    if (run_cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [hbwd_pkg::LIMIT_W-1:0] lim;
    logic [hbwd_pkg::MODE_W-1:0]  wat;
    int                           cause_pick;
    int                           kchg;
    int                           wchg;
    int                           watch;

    wd_now = '{primed: 1'b0, last_k: '0, last_w: '0, k_cnt: '0, w_cnt: '0,
               halted: 1'b0, cause: hbwd_pkg::CAUSE_NONE, pets: '0};
    wd_plan = wd_now;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset register values. The first tick only primes
    // the channels; the next ones walk both sequences across their extremes, pet the
    // kernel, and move the worker in and out of the watched state.
    set_idling(IDLE_NONE);
    directed_tick(32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
    directed_tick(32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
    directed_tick(32'h0000_0000, 32'hFFFF_FFFF, 8'h03);
    directed_tick(32'h0000_0000, 32'hFFFF_FFFF, 8'h03);
    directed_tick(32'h8000_0000, 32'hFFFF_FFFF, 8'h03);
    directed_tick(32'h8000_0000, 32'h7FFF_FFFF, 8'h03);
    directed_tick(32'h8000_0000, 32'h7FFF_FFFF, 8'h02);
    drain();

    // Tight limit, watched state at the top code with junk in the upper data bits,
    // and writes to the unmapped indexes, which must change nothing. The counts
    // carry over the writes.
    write_reg(hbwd_pkg::REG_TIMEOUT_LIMIT, 16'd2);
    write_reg(hbwd_pkg::REG_WATCHED_STATE, 16'hA5FF);
    write_reg(REG_UNMAPPED_LO, 16'h0000);
    write_reg(REG_UNMAPPED_HI, 16'hFFFF);
    directed_tick(32'h1234_5678, 32'h7FFF_FFFF, 8'hFF);
    directed_tick(32'h1234_5678, 32'h7FFF_FFFF, 8'hFE);
    directed_tick(32'h1234_5678, 32'h7FFF_FFFF, 8'hFF);
    directed_tick(32'hEDCB_A987, 32'h0000_0001, 8'h00);
    directed_tick(32'hEDCB_A987, 32'h0000_0001, 8'hFF);
    directed_tick(32'h5555_5555, 32'hAAAA_AAAA, 8'h80);
    drain();

    // Random phases, each with its own register setting and idling pattern. The
    // limit visits zero, one below the top of its range, the top itself, a random value,
    // and short values where the counts keep brushing against the limit.
    for (int i = 0; i < RANDOM_PHASES; i++) begin
      case (i)
        0:       lim = '0;
        1:       lim = 16'd65534;
        4:       lim = hbwd_pkg::LIMIT_W'($urandom_range(65534));
        7:       lim = '1;
        default: lim = hbwd_pkg::LIMIT_W'($urandom_range(1, 16));
      endcase
      case (i)
        0:       wat = '0;
        1:       wat = '1;
        default: wat = hbwd_pkg::MODE_W'($urandom_range(255));
      endcase
      write_reg(hbwd_pkg::REG_TIMEOUT_LIMIT, lim);
      write_reg(hbwd_pkg::REG_WATCHED_STATE, {8'($urandom), wat});
      if (i == 3) write_reg(REG_UNMAPPED_LO, 16'($urandom));
      set_idling(idling_t'(i % 4));
      kchg  = $urandom_range(15, 70);
      wchg  = $urandom_range(15, 70);
      watch = $urandom_range(40, 90);
      make_ticks(PHASE_TICKS, kchg, wchg, watch, 1'b0);
      // With the sender free-running, a long receiver hold-off fills the result
      // slot and must stall the input channel.
      if (i == 4) hold_req++;
      drain();
    end

    // Quiet stretch with no limit in reach: both sequences frozen and the worker
    // watched, so both idle counts climb without a trip.
    set_idling(IDLE_NONE);
    write_reg(hbwd_pkg::REG_TIMEOUT_LIMIT, '1);
    make_ticks(1, 100, 100, 100, 1'b0);
    make_ticks(SOAK_TICKS, 0, 0, 100, 1'b0);
    drain();

    // Final phase: bring the watchdog down. The idle counts from the quiet stretch
    // are still there, so the first tick is steered to fresh sequences. The trip then
    // comes from the kernel alone, the worker alone, or both on the same tick, where
    // the kernel must win. After the trip the block is frozen and only the pet total
    // moves.
    set_idling(IDLE_BOTH);
    write_reg(hbwd_pkg::REG_TIMEOUT_LIMIT, hbwd_pkg::LIMIT_W'($urandom_range(0, 6)));
    write_reg(hbwd_pkg::REG_WATCHED_STATE, 16'($urandom));
    make_ticks(1, 100, 100, 100, 1'b0);
    cause_pick = $urandom_range(2);
    while (!wd_plan.halted) begin
      case (cause_pick)
        0:       make_ticks(1, 0, 100, 50, 1'b1);
        1:       make_ticks(1, 100, 0, 100, 1'b1);
        default: make_ticks(1, 0, 0, 100, 1'b1);
      endcase
    end
    make_ticks(FROZEN_TICKS, 50, 50, 50, 1'b1);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
